/* rtl/core/vram_rect_fill_copy_macros.svh */
// Assertion helpers shared by the frame store block.
// Every use samples on clk and is quiet while arst_n is low.
`ifndef VRAM_RECT_FILL_COPY_MACROS_SVH
`define VRAM_RECT_FILL_COPY_MACROS_SVH

// Same-cycle implication.
`define VRFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VRFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/vrfc_pkg.sv */
`default_nettype none
package vrfc_pkg;

	localparam int FRAME_W     = 1024;
	localparam int FRAME_H     = 512;
	localparam int X_W         = $clog2(FRAME_W);
	localparam int Y_W         = $clog2(FRAME_H);
	localparam int ADDR_W      = X_W + Y_W;
	localparam int STORE_DEPTH = FRAME_W * FRAME_H;
	localparam int PIX_W       = 16;
	localparam int RAW_W       = 16;

	localparam logic [1:0] CMD_FILL = 2'd0;
	localparam logic [1:0] CMD_COPY = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_SKIPPED  = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_REJECTED = 2'd3;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [RAW_W-1:0] x_a;
		logic [RAW_W-1:0] y_a;
		logic [RAW_W-1:0] x_b;
		logic [RAW_W-1:0] y_b;
		logic [RAW_W-1:0] rect_width;
		logic [RAW_W-1:0] rect_height;
		logic [PIX_W-1:0] fill_colour;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PIX_W-1:0] pixel_value;
	} rsp_item_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [PIX_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic      valid;
		rsp_item_t rsp;
	} seq_done_t;

endpackage
`default_nettype wire

/* rtl/core/vram_rect_fill_copy.sv */
`default_nettype none
// Frame store of 1024 by 512 16-bit pixels driven by one command item at a
// time: fill a clipped rectangle with one colour, copy a rectangle forward
// through the store, or read one pixel; every command returns one result
// item (status, pixel), also a skipped fill, a fill clipped to nothing, a
// rejected or zero-area copy and an unused command code. A copy handles each
// pixel as a registered read and then its write, so overlapping copies see
// their own writes. One sequencer walks the store; cmd_stall stays high from
// acceptance until the result moves into the output register, which may
// still be waiting on rsp_stall. The store has no clearing pass after reset:
// read only pixels that were written. skip_fills is written over the cfg
// port, which is always ready, and must change only while the block is idle.

`include "vram_rect_fill_copy_macros.svh"

module vram_rect_fill_copy
	import vrfc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output      logic      cmd_stall,
	input  wire cmd_item_t cmd_item,
	output      logic      rsp_valid,
	input  wire logic      rsp_stall,
	output      rsp_item_t rsp_item,
	input  wire logic      cfg_valid,
	output      logic      cfg_ready,
	input  wire logic      cfg_skip_fills
);

	logic             skip_fills_q;
	logic             seq_idle;
	seq_done_t        seq_done;
	logic             done_take;
	logic             start;
	ram_req_t         ram_req;
	logic [PIX_W-1:0] ram_rdata;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	// Configuration: one register, written whenever offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_fills_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			skip_fills_q <= cfg_skip_fills;
		end
	end

	// Take a new item only while the sequencer sits idle.
	assign cmd_stall = !seq_idle;
	assign start     = cmd_valid && seq_idle;

	// Move the finished result into the output register when it is free or
	// being drained this cycle.
	assign done_take = seq_done.valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) rsp_q <= seq_done.rsp;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	vrfc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (cmd_item),
		.skip_fills (skip_fills_q),
		.idle       (seq_idle),
		.done       (seq_done),
		.done_take  (done_take),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	vrfc_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// An accepted item always occupies the sequencer next cycle.
	`VRFC_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, !seq_idle, "accept left seq idle")
	// A held result is never overwritten.
	`VRFC_ASSERT_NOW(a_no_overwrite, rsp_valid_q && rsp_stall, !done_take, "result overwritten")
	// The store is written only while a command is in flight.
	`VRFC_ASSERT_NOW(a_write_when_busy, ram_req.we, !seq_idle, "store written while idle")
	// Only a completed command may carry a nonzero pixel.
	`VRFC_ASSERT_NOW(a_pixel_only_done, rsp_valid_q && (rsp_q.status != ST_DONE), rsp_q.pixel_value == '0, "pixel on failed command")
	// Handing off the result frees the sequencer.
	`VRFC_ASSERT_NEXT(a_idle_after_result, done_take, seq_idle, "seq not idle after result")

endmodule
`default_nettype wire

/* rtl/core/vrfc_ram.sv */
`default_nettype none
module vrfc_ram
	import vrfc_pkg::*;
(
	input  wire logic             clk,
	input  wire ram_req_t         req,
	output      logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/vrfc_seq.sv */
`default_nettype none
module vrfc_seq
	import vrfc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire cmd_item_t        item,
	input  wire logic             skip_fills,
	output      logic             idle,
	output      seq_done_t        done,
	input  wire logic             done_take,
	output      ram_req_t         ram_req,
	input  wire logic [PIX_W-1:0] ram_rdata
);

	localparam int CLIP_W = RAW_W + 2;
	localparam int SUM_W  = RAW_W + 1;
	localparam logic signed [CLIP_W-1:0] CLIP_FW = CLIP_W'(FRAME_W);
	localparam logic signed [CLIP_W-1:0] CLIP_FH = CLIP_W'(FRAME_H);
	localparam logic [SUM_W-1:0] SUM_FH = SUM_W'(FRAME_H);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_CLIP = 4'd2;
	localparam logic [3:0] S_FILL = 4'd3;
	localparam logic [3:0] S_CRD  = 4'd4;
	localparam logic [3:0] S_CWR  = 4'd5;
	localparam logic [3:0] S_RRD  = 4'd6;
	localparam logic [3:0] S_RDAT = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;

	cmd_item_t                item_q;
	logic signed [CLIP_W-1:0] xe_q, ye_q;
	logic [ADDR_W-1:0]        src_q, dst_q;
	logic [X_W-1:0]           src_x_q, dst_x_q;
	logic [Y_W-1:0]           src_y_q, dst_y_q;
	logic [RAW_W-1:0]         col_len_q, col_cnt_q, row_cnt_q;
	logic [1:0]               status_q;
	logic [PIX_W-1:0]         pixel_q;

	// fill clipping
	logic signed [CLIP_W-1:0] x0s, y0s, ws, hs, x0c, y0c, xec, yec;
	logic                     clip_empty;

	// copy checks
	logic [X_W-1:0]   csx, cdx;
	logic [Y_W-1:0]   csy, cdy;
	logic [SUM_W-1:0] cs_end, cd_end;
	logic             cpy_reject, cpy_zero;

	// shared walk step
	logic              last_col, last_row, step_done;
	logic [ADDR_W-1:0] src_nxt, dst_nxt;
	logic [Y_W-1:0]    src_y_nxt, dst_y_nxt;
	logic [RAW_W-1:0]  col_nxt, row_nxt;

	always_comb begin
		x0s = $signed({{(CLIP_W-RAW_W){item_q.x_a[RAW_W-1]}}, item_q.x_a});
		y0s = $signed({{(CLIP_W-RAW_W){item_q.y_a[RAW_W-1]}}, item_q.y_a});
		ws  = $signed({{(CLIP_W-RAW_W){item_q.rect_width[RAW_W-1]}}, item_q.rect_width});
		hs  = $signed({{(CLIP_W-RAW_W){item_q.rect_height[RAW_W-1]}}, item_q.rect_height});
		x0c = (x0s < 0) ? '0 : x0s;
		y0c = (y0s < 0) ? '0 : y0s;
		xec = (xe_q > CLIP_FW) ? CLIP_FW : xe_q;
		yec = (ye_q > CLIP_FH) ? CLIP_FH : ye_q;
		clip_empty = (xec <= x0c) || (yec <= y0c);
	end

	always_comb begin
		csx = item_q.x_a[X_W-1:0];
		csy = item_q.y_a[Y_W-1:0];
		cdx = item_q.x_b[X_W-1:0];
		cdy = item_q.y_b[Y_W-1:0];
		cs_end = {{(SUM_W-Y_W){1'b0}}, csy} + {1'b0, item_q.rect_height};
		cd_end = {{(SUM_W-Y_W){1'b0}}, cdy} + {1'b0, item_q.rect_height};
		cpy_reject = ((csx == cdx) && (csy == cdy)) || (cs_end > SUM_FH) || (cd_end > SUM_FH);
		cpy_zero = (item_q.rect_width == '0) || (item_q.rect_height == '0);
	end

	// advance both pointers; a new row restarts at the row's left edge
	always_comb begin
		last_col  = (col_cnt_q == RAW_W'(1));
		last_row  = (row_cnt_q == RAW_W'(1));
		step_done = last_col && last_row;
		if (last_col) begin
			src_y_nxt = Y_W'(src_y_q + 1'b1);
			dst_y_nxt = Y_W'(dst_y_q + 1'b1);
			src_nxt   = {src_y_nxt, src_x_q};
			dst_nxt   = {dst_y_nxt, dst_x_q};
			col_nxt   = col_len_q;
			row_nxt   = RAW_W'(row_cnt_q - 1'b1);
		end else begin
			src_y_nxt = src_y_q;
			dst_y_nxt = dst_y_q;
			src_nxt   = ADDR_W'(src_q + 1'b1);
			dst_nxt   = ADDR_W'(dst_q + 1'b1);
			col_nxt   = RAW_W'(col_cnt_q - 1'b1);
			row_nxt   = row_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: begin
					unique case (item_q.cmd)
						CMD_FILL: state_q <= skip_fills ? S_DONE : S_CLIP;
						CMD_COPY: state_q <= (cpy_reject || cpy_zero) ? S_DONE : S_CRD;
						CMD_READ: state_q <= S_RRD;
						default:  state_q <= S_DONE;
					endcase
				end
				S_CLIP: state_q <= clip_empty ? S_DONE : S_FILL;
				S_FILL: if (step_done) state_q <= S_DONE;
				S_CRD:  state_q <= S_CWR;
				S_CWR:  state_q <= step_done ? S_DONE : S_CRD;
				S_RRD:  state_q <= S_RDAT;
				S_RDAT: state_q <= S_DONE;
				S_DONE: if (done_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) item_q <= item;
			S_DEC: begin
				status_q <= ST_DONE;
				pixel_q  <= '0;
				unique case (item_q.cmd)
					CMD_FILL: begin
						if (skip_fills) status_q <= ST_SKIPPED;
						xe_q <= x0s + ws;
						ye_q <= y0s + hs;
					end
					CMD_COPY: begin
						if (cpy_reject) status_q <= ST_REJECTED;
						src_q     <= {csy, csx};
						dst_q     <= {cdy, cdx};
						src_x_q   <= csx;
						src_y_q   <= csy;
						dst_x_q   <= cdx;
						dst_y_q   <= cdy;
						col_len_q <= item_q.rect_width;
						col_cnt_q <= item_q.rect_width;
						row_cnt_q <= item_q.rect_height;
					end
					CMD_READ: src_q <= {csy, csx};
					default: ;
				endcase
			end
			S_CLIP: begin
				if (clip_empty) status_q <= ST_EMPTY;
				dst_q     <= {y0c[Y_W-1:0], x0c[X_W-1:0]};
				dst_x_q   <= x0c[X_W-1:0];
				dst_y_q   <= y0c[Y_W-1:0];
				col_len_q <= RAW_W'(xec - x0c);
				col_cnt_q <= RAW_W'(xec - x0c);
				row_cnt_q <= RAW_W'(yec - y0c);
			end
			S_FILL, S_CWR: begin
				src_q     <= src_nxt;
				dst_q     <= dst_nxt;
				src_y_q   <= src_y_nxt;
				dst_y_q   <= dst_y_nxt;
				col_cnt_q <= col_nxt;
				row_cnt_q <= row_nxt;
			end
			S_RDAT: pixel_q <= ram_rdata;
			default: ;
		endcase
	end

	always_comb begin
		ram_req.we    = (state_q == S_FILL) || (state_q == S_CWR);
		ram_req.waddr = dst_q;
		ram_req.wdata = (state_q == S_FILL) ? item_q.fill_colour : ram_rdata;
		ram_req.raddr = src_q;
	end

	assign idle                   = (state_q == S_IDLE);
	assign done.valid             = (state_q == S_DONE);
	assign done.rsp.status        = status_q;
	assign done.rsp.pixel_value   = pixel_q;

endmodule
`default_nettype wire
